@@ src/md5_hash_engine_defines.svh @@
// Assertion macros used by the MD5 engine back end.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef MD5_HASH_ENGINE_DEFINES_SVH
`define MD5_HASH_ENGINE_DEFINES_SVH

// Implication within the same cycle.
`define MD5_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("md5 assertion failed");

// Implication into the following cycle.
`define MD5_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("md5 assertion failed");

`endif

@@ src/md5_pkg.sv @@
// Package of the MD5 engine: constants, block queue entry type and round tables.
// Used by every module of the engine; depends on nothing.
package md5_pkg;

	localparam int QueueDepth = 2;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0]  PAD_MARK = 8'h80;
	localparam logic [5:0]  LEN_POS = 6'd56;
	localparam logic [5:0]  LAST_POS = 6'd63;
	localparam logic [5:0]  LAST_ROUND = 6'd63;

	typedef struct packed {
		logic         final_blk;
		logic [511:0] data;
	} blk_entry_t;

	typedef enum logic {
		F_TAKE,
		F_PAD
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RUN,
		B_OUT
	} back_state_t;

	function automatic logic [31:0] round_const(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] msg_index(input logic [5:0] r);
		logic [3:0] g;
		case (r[5:4])
			2'd0: g = r[3:0];
			2'd1: g = 4'(r[3:0] * 4'd5 + 4'd1);
			2'd2: g = 4'(r[3:0] * 4'd3 + 4'd5);
			default: g = 4'(r[3:0] * 4'd7);
		endcase
		return g;
	endfunction

endpackage

@@ src/md5_fifo.sv @@
// Short queue of complete 64-byte blocks between the front and the back.
// Depends on md5_pkg for the entry type and the default depth.
module md5_fifo #(
	parameter int Depth = md5_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  md5_pkg::blk_entry_t push_data,
	output logic                full,
	input  logic                pop,
	output md5_pkg::blk_entry_t pop_data,
	output logic                empty
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	md5_pkg::blk_entry_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full = (cnt_q == CntW'(Depth));
	assign empty = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CntW'(push && !full) - CntW'(pop && !empty);
		end
	end
endmodule

@@ src/md5_front.sv @@
// Front end: accepts beats, packs bytes into blocks, counts length and pads on finish.
// Depends on md5_pkg; feeds md5_fifo.
module md5_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [7:0]          data_byte,
	output logic                push,
	output md5_pkg::blk_entry_t push_data,
	input  logic                q_full
);
	md5_pkg::front_state_t state_q, state_d;
	logic [511:0] blk_q, blk_nxt;
	logic [5:0]   fill_q, fill_inc;
	logic [63:0]  bitlen_q, len_q;
	logic         mark_q, len_ph_q;
	logic         wr_en, take;
	logic [7:0]   wr_byte, pad_byte;

	assign fill_inc = fill_q + 6'd1;

	always_comb begin
		if (mark_q) begin
			pad_byte = md5_pkg::PAD_MARK;
		end else if (len_ph_q) begin
			pad_byte = len_q[{fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		take = 1'b0;
		wr_en = 1'b0;
		wr_byte = data_byte;
		case (state_q)
			md5_pkg::F_TAKE: begin
				in_stall = q_full;
				take = in_valid && !q_full;
				if (take && !kind) begin
					wr_en = 1'b1;
				end else if (take) begin
					state_d = md5_pkg::F_PAD;
				end
			end
			md5_pkg::F_PAD: begin
				wr_byte = pad_byte;
				wr_en = !(fill_q == md5_pkg::LAST_POS && q_full);
				if (wr_en && len_ph_q && fill_q == md5_pkg::LAST_POS) begin
					state_d = md5_pkg::F_TAKE;
				end
			end
			default: state_d = md5_pkg::F_TAKE;
		endcase
	end

	always_comb begin
		blk_nxt = blk_q;
		blk_nxt[{fill_q, 3'b000} +: 8] = wr_byte;
	end

	assign push = wr_en && (fill_q == md5_pkg::LAST_POS);
	assign push_data.data = blk_nxt;
	assign push_data.final_blk = (state_q == md5_pkg::F_PAD) && len_ph_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			blk_q <= blk_nxt;
		end
		if (take && kind) begin
			len_q <= bitlen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5_pkg::F_TAKE;
			fill_q <= '0;
			bitlen_q <= '0;
			mark_q <= 1'b0;
			len_ph_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				fill_q <= fill_inc;
			end
			if (state_q == md5_pkg::F_TAKE) begin
				if (take && !kind) begin
					bitlen_q <= bitlen_q + 64'd8;
				end else if (take) begin
					mark_q <= 1'b1;
					len_ph_q <= 1'b0;
				end
			end else if (wr_en) begin
				mark_q <= 1'b0;
				len_ph_q <= len_ph_q || (fill_inc == md5_pkg::LEN_POS);
				if (state_d == md5_pkg::F_TAKE) begin
					bitlen_q <= '0;
					len_ph_q <= 1'b0;
				end
			end
		end
	end
endmodule

@@ src/md5_back.sv @@
// Back end: runs the 64 MD5 rounds on queued blocks, one round per cycle, and emits digests.
// Depends on md5_pkg and the assertion macros header.
`include "md5_hash_engine_defines.svh"

module md5_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  md5_pkg::blk_entry_t q_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         digest_word,
	output logic [1:0]          word_index,
	output logic                last_word
);
	md5_pkg::back_state_t state_q, state_d;
	logic [511:0] blk_q;
	logic         fin_q;
	logic [5:0]   rnd_q;
	logic [1:0]   idx_q;
	logic [31:0]  a_q, b_q, c_q, d_q;
	logic [31:0]  chain_q [4];
	logic [31:0]  f, t, w, rot, b_new;
	logic [63:0]  dbl;
	logic         out_take;

	always_comb begin
		case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		w = blk_q[{md5_pkg::msg_index(rnd_q), 5'b00000} +: 32];
		t = a_q + f + w + md5_pkg::round_const(rnd_q);
		dbl = {t, t} << md5_pkg::rot_amount(rnd_q);
		rot = dbl[63:32];
		b_new = b_q + rot;
	end

	assign out_valid = (state_q == md5_pkg::B_OUT);
	assign out_take = out_valid && !out_stall;
	assign digest_word = chain_q[idx_q];
	assign word_index = idx_q;
	assign last_word = (idx_q == 2'd3);

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		case (state_q)
			md5_pkg::B_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					state_d = md5_pkg::B_RUN;
				end
			end
			md5_pkg::B_RUN: begin
				if (rnd_q == md5_pkg::LAST_ROUND) begin
					state_d = fin_q ? md5_pkg::B_OUT : md5_pkg::B_IDLE;
				end
			end
			md5_pkg::B_OUT: begin
				if (out_take && idx_q == 2'd3) begin
					state_d = md5_pkg::B_IDLE;
				end
			end
			default: state_d = md5_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			blk_q <= q_data.data;
			fin_q <= q_data.final_blk;
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (state_q == md5_pkg::B_RUN) begin
			a_q <= d_q;
			b_q <= b_new;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5_pkg::B_IDLE;
			rnd_q <= '0;
			idx_q <= '0;
			chain_q[0] <= md5_pkg::IV_A;
			chain_q[1] <= md5_pkg::IV_B;
			chain_q[2] <= md5_pkg::IV_C;
			chain_q[3] <= md5_pkg::IV_D;
		end else begin
			state_q <= state_d;
			if (pop) begin
				rnd_q <= '0;
			end else if (state_q == md5_pkg::B_RUN) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == md5_pkg::LAST_ROUND) begin
					chain_q[0] <= chain_q[0] + d_q;
					chain_q[1] <= chain_q[1] + b_new;
					chain_q[2] <= chain_q[2] + b_q;
					chain_q[3] <= chain_q[3] + c_q;
					idx_q <= '0;
				end
			end
			if (out_take) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					chain_q[0] <= md5_pkg::IV_A;
					chain_q[1] <= md5_pkg::IV_B;
					chain_q[2] <= md5_pkg::IV_C;
					chain_q[3] <= md5_pkg::IV_D;
				end
			end
		end
	end

	`MD5_ASSERT_NEXT(a_pop_starts, state_q == md5_pkg::B_IDLE && !q_empty, state_q == md5_pkg::B_RUN && rnd_q == 6'd0)
	`MD5_ASSERT_NEXT(a_mid_block, state_q == md5_pkg::B_RUN && rnd_q == md5_pkg::LAST_ROUND && !fin_q, state_q == md5_pkg::B_IDLE)
	`MD5_ASSERT_NEXT(a_iv_reload, out_take && idx_q == 2'd3, chain_q[0] == md5_pkg::IV_A && chain_q[3] == md5_pkg::IV_D)
endmodule

@@ src/md5_hash_engine.sv @@
// Beat    Direction  Handshake            Payload
// input   in         in_valid / in_stall  kind, data_byte
// output  out        out_valid/out_stall  digest_word, word_index, last_word
//
// A message byte is packed into the current block; a full block then waits in the queue.
// A finish beat pads one byte per cycle, one or two blocks, and a full queue can hold it;
// the back end loads and hashes each block, and after the last emits four digest beats.
// Reset is asynchronous and active low and loads the standard initial chaining values.
// The input stalls while the block queue is full or padding is in progress.
module md5_hash_engine #(
	parameter int QDepth = md5_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);
	md5_pkg::blk_entry_t push_data, pop_data;
	logic push, pop, q_full, q_empty;

	md5_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.data_byte(data_byte),
		.push(push),
		.push_data(push_data),
		.q_full(q_full)
	);

	md5_fifo #(.Depth(QDepth)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(q_full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(q_empty)
	);

	md5_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_data(pop_data),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);
endmodule
